// ----- rtl/assert_macros.svh -----
// assertion helpers used by the rtl register file core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet while rst is high
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet while rst is high
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/mmurf_pkg.sv -----
package mmurf_pkg;

  // sizes
  localparam int MapEntries   = 64;
  localparam int PagesPerMode = 16;
  localparam int PageSlots    = 3;
  localparam int PageWords    = PageSlots * PagesPerMode;
  localparam int MapIdxW      = $clog2(MapEntries);
  localparam int PageIdxW     = $clog2(PageWords);
  localparam int AddrW        = 22;
  localparam int DataW        = 16;
  localparam int Sr3W         = 6;

  // access modes
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_PROBE = 2'd3
  } mode_t;

  // page register slots
  localparam logic [1:0] SLOT_KERNEL = 2'd0;
  localparam logic [1:0] SLOT_SUPER  = 2'd1;
  localparam logic [1:0] SLOT_USER   = 2'd2;

  // address map (octal)
  localparam logic [AddrW-1:0] MAP_LO      = 22'o17770200;
  localparam logic [AddrW-1:0] MAP_HI      = 22'o17770376;
  localparam logic [AddrW-1:0] SR0_ADDR    = 22'o17777572;
  localparam logic [AddrW-1:0] SR1_ADDR    = 22'o17777574;
  localparam logic [AddrW-1:0] SR2_ADDR    = 22'o17777576;
  localparam logic [AddrW-1:0] SR3_ADDR    = 22'o17772516;
  localparam logic [AddrW-1:0] KERNEL_BASE = 22'o17772300;
  localparam logic [AddrW-1:0] SUPER_BASE  = 22'o17772200;
  localparam logic [AddrW-1:0] USER_BASE   = 22'o17777600;

  // write masks
  localparam logic [DataW-1:0] PDR_MASK      = 16'o077417;
  localparam logic [DataW-1:0] PDR_AW_BITS   = 16'o000300;
  localparam logic [DataW-1:0] MAP_ODD_MASK  = 16'o000077;
  localparam logic [DataW-1:0] MAP_EVEN_MASK = 16'o177776;
  localparam logic [Sr3W-1:0]  SR3_MASK      = 6'o67;

  typedef struct packed {
    mode_t             mode;
    logic [AddrW-1:0]  address;
    logic [DataW-1:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic              bus_error;
    logic              internal_hit;
  } rsp_t;

  // address decode result
  typedef struct packed {
    logic                 map_hit;
    logic [MapIdxW-1:0]   map_idx;
    logic                 sr0;
    logic                 sr1;
    logic                 sr2;
    logic                 sr3;
    logic                 page_hit;
    logic                 page_par;
    logic [PageIdxW-1:0]  page_idx;
  } dec_t;

endpackage

// ----- rtl/mmurf_decode.sv -----
module mmurf_decode (
  input  mmurf_pkg::req_t req,
  output mmurf_pkg::dec_t dec
);
  import mmurf_pkg::*;

  logic [AddrW-1:0] addr;
  logic [AddrW-1:0] group;
  logic [1:0]       slot;
  logic             slot_hit;

  always_comb begin
    addr  = req.address;
    // page block group ignores the block select and page bits
    group = {addr[AddrW-1:6], 6'b000000};
    slot_hit = 1'b1;
    case (group)
      KERNEL_BASE: slot = SLOT_KERNEL;
      SUPER_BASE:  slot = SLOT_SUPER;
      USER_BASE:   slot = SLOT_USER;
      default: begin
        slot     = SLOT_KERNEL;
        slot_hit = 1'b0;
      end
    endcase

    // bus map range, byte bit ignored
    dec.map_hit = (addr >= MAP_LO) && (addr <= MAP_HI);
    dec.map_idx = addr[MapIdxW:1];

    // status registers decode at their exact address only
    dec.sr0 = (addr == SR0_ADDR);
    dec.sr1 = (addr == SR1_ADDR);
    dec.sr2 = (addr == SR2_ADDR);
    dec.sr3 = (addr == SR3_ADDR);

    // upper block of a pair serves pages 8..15
    dec.page_hit = slot_hit;
    dec.page_par = addr[5];
    dec.page_idx = {slot, addr[4], addr[3:1]};
  end

endmodule

// ----- rtl/mmu_register_file_decode_core.sv -----
// Register bank of a memory management unit, addressed by 22-bit bus address.
// Request channel (req_valid / req_stall / req) carries mode, address and
// write data; response channel (rsp_valid / rsp_stall / rsp) returns one item
// per request: read data, bus error flag and probe hit flag.
// Modes: read, write, bus init (clears bus map, SR0 and SR3) and probe.
// An item passes an input register, then the decode and the write port and
// registered read port of each table (bus map, PAR, PDR) into the result
// register. One item is accepted per cycle for as long as results are taken.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more; req_stall rises after that.
// Reset clears both pipeline stages, SR0, SR3 and the entry valid bits of
// the bus map and page tables, so every word reads zero afterwards.
// Bus init drops all bus map valid bits at once; page words survive it.
// Writing a PAR sets a per-page flag that masks the access and written bits
// of the matching PDR until that PDR is written again.
`include "assert_macros.svh"

module mmu_register_file_decode_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mmurf_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mmurf_pkg::rsp_t rsp
);
  import mmurf_pkg::*;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_WORD,
    SEL_MAP,
    SEL_PAR,
    SEL_PDR
  } sel_t;

  // input stage
  logic  s1_valid;
  req_t  s1;
  logic  accept;
  logic  adv;
  dec_t  dec;

  // decoded actions
  logic  is_read, is_write, is_init, is_probe;
  logic  any_status, any_reg;
  logic  map_we, sr0_we, sr3_we, par_we, pdr_we, init_go;
  logic [DataW-1:0] map_wdata;
  sel_t             sel_next;
  logic [DataW-1:0] word_next;
  logic             ent_valid_next;

  // state
  logic [DataW-1:0] map_mem [MapEntries];
  logic [DataW-1:0] par_mem [PageWords];
  logic [DataW-1:0] pdr_mem [PageWords];
  logic [MapEntries-1:0] map_valid;
  logic [PageWords-1:0]  par_valid;
  logic [PageWords-1:0]  pdr_valid;
  logic [PageWords-1:0]  pdr_aw_clr;
  logic [DataW-1:0]      sr0_q;
  logic [Sr3W-1:0]       sr3_q;

  // result stage
  sel_t             o_sel;
  logic [DataW-1:0] o_word;
  logic [DataW-1:0] map_q, par_q, pdr_q;
  logic             o_ent_valid;
  logic             o_aw_clr;
  logic             o_err;
  logic             o_hit;

  // handshake
  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= req;
    end
  end

  mmurf_decode u_decode (
    .req (s1),
    .dec (dec)
  );

  // mode and target decode
  always_comb begin
    is_read    = (s1.mode == MODE_READ);
    is_write   = (s1.mode == MODE_WRITE);
    is_init    = (s1.mode == MODE_INIT);
    is_probe   = (s1.mode == MODE_PROBE);
    any_status = dec.sr0 || dec.sr1 || dec.sr2 || dec.sr3;
    any_reg    = dec.map_hit || any_status || dec.page_hit;

    map_we  = adv && is_write && dec.map_hit;
    sr0_we  = adv && is_write && !dec.map_hit && dec.sr0;
    sr3_we  = adv && is_write && !dec.map_hit && dec.sr3;
    par_we  = adv && is_write && !dec.map_hit && !any_status && dec.page_hit
              && dec.page_par;
    pdr_we  = adv && is_write && !dec.map_hit && !any_status && dec.page_hit
              && !dec.page_par;
    init_go = adv && is_init;

    map_wdata = dec.map_idx[0] ? (s1.write_data & MAP_ODD_MASK)
                               : (s1.write_data & MAP_EVEN_MASK);

    // read source selection
    sel_next       = SEL_NONE;
    word_next      = '0;
    ent_valid_next = 1'b0;
    if (is_read) begin
      if (dec.map_hit) begin
        sel_next       = SEL_MAP;
        ent_valid_next = map_valid[dec.map_idx];
      end else if (any_status) begin
        sel_next = SEL_WORD;
        if (dec.sr0) begin
          word_next = sr0_q;
        end else if (dec.sr3) begin
          word_next = {{(DataW-Sr3W){1'b0}}, sr3_q};
        end
      end else if (dec.page_hit) begin
        if (dec.page_par) begin
          sel_next       = SEL_PAR;
          ent_valid_next = par_valid[dec.page_idx];
        end else begin
          sel_next       = SEL_PDR;
          ent_valid_next = pdr_valid[dec.page_idx];
        end
      end
    end
  end

  // table ports: a write for write items, a registered read for every item
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[dec.map_idx] <= map_wdata;
    end
    if (adv) begin
      map_q <= map_mem[dec.map_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[dec.page_idx] <= s1.write_data;
    end
    if (adv) begin
      par_q <= par_mem[dec.page_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pdr_we) begin
      pdr_mem[dec.page_idx] <= s1.write_data & PDR_MASK;
    end
    if (adv) begin
      pdr_q <= pdr_mem[dec.page_idx];
    end
  end

  // status registers, valid bits and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid  <= '0;
      par_valid  <= '0;
      pdr_valid  <= '0;
      pdr_aw_clr <= '0;
      sr0_q      <= '0;
      sr3_q      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (init_go) begin
        map_valid <= '0;
        sr0_q     <= '0;
        sr3_q     <= '0;
      end
      if (map_we) begin
        map_valid[dec.map_idx] <= 1'b1;
      end
      if (sr0_we) begin
        sr0_q <= s1.write_data;
      end
      if (sr3_we) begin
        sr3_q <= s1.write_data[Sr3W-1:0] & SR3_MASK;
      end
      if (par_we) begin
        par_valid[dec.page_idx]  <= 1'b1;
        pdr_aw_clr[dec.page_idx] <= 1'b1;
      end
      if (pdr_we) begin
        pdr_valid[dec.page_idx]  <= 1'b1;
        pdr_aw_clr[dec.page_idx] <= 1'b0;
      end
      if (adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      o_sel       <= sel_next;
      o_word      <= word_next;
      o_ent_valid <= ent_valid_next;
      o_aw_clr    <= pdr_aw_clr[dec.page_idx];
      o_err       <= (is_read || is_write) && !any_reg;
      o_hit       <= is_probe && (any_status || dec.page_hit);
    end
  end

  // response mux after the table read registers
  always_comb begin
    rsp.bus_error    = o_err;
    rsp.internal_hit = o_hit;
    case (o_sel)
      SEL_WORD: rsp.read_data = o_word;
      SEL_MAP:  rsp.read_data = o_ent_valid ? map_q : '0;
      SEL_PAR:  rsp.read_data = o_ent_valid ? par_q : '0;
      SEL_PDR:  rsp.read_data = o_ent_valid
                                ? (o_aw_clr ? (pdr_q & ~PDR_AW_BITS) : pdr_q) : '0;
      default:  rsp.read_data = '0;
    endcase
  end

  // checks
  `ASSERT_IMPL(a_err_no_data, rsp_valid && rsp.bus_error, rsp.read_data == '0, "read data on error")
  `ASSERT_IMPL(a_err_not_hit, rsp_valid, !(rsp.bus_error && rsp.internal_hit), "error and hit together")
  `ASSERT_NEXT(a_init_clears, adv && is_init, (map_valid == '0) && (sr0_q == '0), "bus init left state")
  `ASSERT_IMPL(a_sr3_masked, 1'b1, sr3_q[3] == 1'b0, "sr3 holds a masked bit")

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmurf_pkg::*;

  localparam int RandomItems = 1650;
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 600000;

  // one row of the directed table; want_* is only used where typed is set
  typedef struct packed {
    mode_t             mode;
    logic [AddrW-1:0]  address;
    logic [DataW-1:0]  write_data;
    logic              typed;
    logic [DataW-1:0]  want_data;
    logic              want_error;
    logic              want_hit;
  } dir_row_t;

  localparam int DirRows = 26;
  localparam dir_row_t DIRECTED_ROWS [DirRows] = '{
    // everything reads zero after reset
    '{MODE_READ,  SR0_ADDR,            16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  SR1_ADDR,            16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  SR2_ADDR,            16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  SR3_ADDR,            16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  MAP_LO,              16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  KERNEL_BASE + 22'o40, 16'h0000, 1'b1, 16'h0000,  1'b0, 1'b0},
    // address extremes hit nothing
    '{MODE_READ,  22'h000000,          16'h0000, 1'b1, 16'h0000,   1'b1, 1'b0},
    '{MODE_WRITE, 22'h3fffff,          16'hffff, 1'b1, 16'h0000,   1'b1, 1'b0},
    // bus map: even words drop bit 0, odd words keep six bits
    '{MODE_WRITE, MAP_LO,              16'hffff, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  MAP_LO,              16'h0000, 1'b1, 16'o177776, 1'b0, 1'b0},
    '{MODE_WRITE, MAP_HI,              16'hffff, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  MAP_HI,              16'h0000, 1'b1, 16'o000077, 1'b0, 1'b0},
    '{MODE_READ,  MAP_HI + 22'd1,      16'h0000, 1'b1, 16'h0000,   1'b1, 1'b0},
    // status registers: sr1 is read-only, sr3 is masked, odd address misses
    '{MODE_WRITE, SR0_ADDR,            16'hffff, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_WRITE, SR1_ADDR,            16'hffff, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  SR1_ADDR,            16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_WRITE, SR3_ADDR,            16'hffff, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  SR3_ADDR,            16'h0000, 1'b1, 16'o000067, 1'b0, 1'b0},
    '{MODE_READ,  SR0_ADDR + 22'd1,    16'h0000, 1'b1, 16'h0000,   1'b1, 1'b0},
    // user page 15: pdr masked, par write clears access and written bits
    '{MODE_WRITE, USER_BASE + 22'o36,  16'hffff, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_WRITE, USER_BASE + 22'o77,  16'ha5c3, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  USER_BASE + 22'o37,  16'h0000, 1'b1, 16'o077417, 1'b0, 1'b0},
    // probe: status register hits, bus map does not
    '{MODE_PROBE, SR3_ADDR,            16'h0000, 1'b1, 16'h0000,   1'b0, 1'b1},
    '{MODE_PROBE, MAP_LO,              16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    // bus init wipes the map, sr0 and sr3, page words survive
    '{MODE_INIT,  22'h000000,          16'h0000, 1'b1, 16'h0000,   1'b0, 1'b0},
    '{MODE_READ,  USER_BASE + 22'o76,  16'h0000, 1'b0, 16'h0000,   1'b0, 1'b0}
  };

  localparam logic [AddrW-1:0] STATUS_ADDRS [4] = '{SR0_ADDR, SR1_ADDR, SR2_ADDR, SR3_ADDR};
  localparam logic [AddrW-1:0] PAGE_BASES [3]   = '{KERNEL_BASE, SUPER_BASE, USER_BASE};

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // register image held by the predictor
  logic [DataW-1:0] map_words  [MapEntries] = '{default: '0};
  logic [DataW-1:0] sr_words   [3]          = '{default: '0};
  logic [Sr3W-1:0]  sr3_word                = '0;
  logic [DataW-1:0] par_words  [PageWords]  = '{default: '0};
  logic [DataW-1:0] pdr_words  [PageWords]  = '{default: '0};

  rsp_t pending_results [$];
  int   error_count  = 0;
  int   cycle_count  = 0;
  int   rx_hold_left = 0;
  int   rx_stall_left = 0;
  logic rx_quiet     = 1'b0;

  mmu_register_file_decode_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // page block decode: word index and par/pdr select
  function automatic logic page_lookup(input logic [AddrW-1:0] a, output int idx,
                                       output logic is_par);
    logic [AddrW-1:0] group;
    logic [1:0] slot;
    group  = a & ~22'o77;
    idx    = 0;
    is_par = 1'b0;
    if (group == KERNEL_BASE) slot = SLOT_KERNEL;
    else if (group == SUPER_BASE) slot = SLOT_SUPER;
    else if (group == USER_BASE) slot = SLOT_USER;
    else return 1'b0;
    idx    = int'(slot) * PagesPerMode + (a[4] ? 8 : 0) + int'(a[3:1]);
    is_par = a[5];
    return 1'b1;
  endfunction

  // applies one access to the register image and returns its result
  function automatic rsp_t predict_register_access(input req_t r);
    rsp_t o;
    int idx;
    logic par;
    logic pg;
    logic in_map;
    logic [MapIdxW-1:0] n;
    o      = '0;
    pg     = page_lookup(r.address, idx, par);
    in_map = (r.address >= MAP_LO) && (r.address <= MAP_HI);
    n      = r.address[6:1];
    case (r.mode)
      MODE_READ: begin
        if (in_map) o.read_data = map_words[n];
        else if (r.address == SR0_ADDR) o.read_data = sr_words[0];
        else if (r.address == SR1_ADDR) o.read_data = sr_words[1];
        else if (r.address == SR2_ADDR) o.read_data = sr_words[2];
        else if (r.address == SR3_ADDR) o.read_data = {10'd0, sr3_word & SR3_MASK};
        else if (pg) o.read_data = par ? par_words[idx] : pdr_words[idx];
        else o.bus_error = 1'b1;
      end
      MODE_WRITE: begin
        if (in_map) begin
          map_words[n] = n[0] ? (r.write_data & MAP_ODD_MASK) : (r.write_data & MAP_EVEN_MASK);
        end else if (r.address == SR0_ADDR) begin
          sr_words[0] = r.write_data;
        end else if (r.address == SR1_ADDR || r.address == SR2_ADDR) begin
          // read-only, write dropped without error
        end else if (r.address == SR3_ADDR) begin
          sr3_word = r.write_data[Sr3W-1:0] & SR3_MASK;
        end else if (pg) begin
          if (par) begin
            par_words[idx] = r.write_data;
            pdr_words[idx] = pdr_words[idx] & ~PDR_AW_BITS;
          end else begin
            pdr_words[idx] = r.write_data & PDR_MASK;
          end
        end else begin
          o.bus_error = 1'b1;
        end
      end
      MODE_INIT: begin
        foreach (map_words[k]) map_words[k] = '0;
        sr_words[0] = '0;
        sr3_word    = '0;
      end
      default: begin
        o.internal_hit = (r.address == SR0_ADDR) || (r.address == SR1_ADDR) ||
                         (r.address == SR2_ADDR) || (r.address == SR3_ADDR) || pg;
      end
    endcase
    return o;
  endfunction

  // sender idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (rx_quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random access aimed mostly at decoded registers
  function automatic req_t random_item();
    req_t item;
    int m;
    m = $urandom_range(0, 99);
    if (m < 45) item.mode = MODE_READ;
    else if (m < 88) item.mode = MODE_WRITE;
    else if (m < 96) item.mode = MODE_PROBE;
    else item.mode = MODE_INIT;
    item.write_data = DataW'($urandom);
    case ($urandom_range(0, 11))
      0, 1, 2: item.address = MAP_LO + AddrW'($urandom_range(0, 8'o177));
      3, 4: item.address = STATUS_ADDRS[$urandom_range(0, 3)] +
                           AddrW'($urandom_range(0, 9) == 0);
      5, 6, 7, 8: item.address = PAGE_BASES[$urandom_range(0, 2)] +
                                 AddrW'($urandom_range(0, 8'o77));
      9: item.address = PAGE_BASES[$urandom_range(0, 2)] - 22'o40 +
                        AddrW'($urandom_range(0, 8'o177));
      default: item.address = AddrW'($urandom);
    endcase
    return item;
  endfunction

  // offer one item, wait for it to be taken, then log its expected result
  task automatic offer_item(input req_t item, input logic typed, input rsp_t want,
                            input int gap, input logic drain);
    rsp_t predicted;
    if (gap > 0 || drain) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (pending_results.size() != 0);
      end
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = predict_register_access(item);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // stimulus
  initial begin
    dir_row_t row;
    req_t item;
    rsp_t want;
    int gap;
    int burst_left;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      row                = DIRECTED_ROWS[i];
      item.mode          = row.mode;
      item.address       = row.address;
      item.write_data    = row.write_data;
      want.read_data     = row.want_data;
      want.bus_error     = row.want_error;
      want.internal_hit  = row.want_hit;
      offer_item(item, row.typed, want, pick_gap(), 1'b0);
    end

    // random accesses with a long receiver hold-off, drain pauses and a quiet stretch
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 300) begin
        rx_hold_left = HoldCycles;
        burst_left   = 40;
      end
      rx_quiet = (i >= 1000 && i < 1200);
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = pick_gap();
      end
      offer_item(random_item(), 1'b0, '0, gap, (i == 700) || (i == 1400));
    end
    req_valid <= 1'b0;

    // wait for the pipeline to empty, then wait on to catch stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver stall: long hold-off on request, random short and long stalls otherwise
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rsp_stall <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        rsp_stall <= 1'b1;
      end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
        rx_stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(9, 39);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %p", rsp);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
          error_count++;
        end
        if (rsp.bus_error !== want.bus_error) begin
          $error("bus_error: expected %b, got %b", want.bus_error, rsp.bus_error);
          error_count++;
        end
        if (rsp.internal_hit !== want.internal_hit) begin
          $error("internal_hit: expected %b, got %b", want.internal_hit, rsp.internal_hit);
          error_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
